@@ src/multi_timer_deadline_scheduler_assert.svh @@
// Assertion macros used by the scheduler engine.
`ifndef MULTI_TIMER_DEADLINE_SCHEDULER_ASSERT_SVH
`define MULTI_TIMER_DEADLINE_SCHEDULER_ASSERT_SVH

// Checks that a condition implies a property on the same edge.
`define MTDS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Checks that a condition implies a property on the next edge.
`define MTDS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

@@ src/mtds_pkg.sv @@
`default_nettype none
package mtds_pkg;

    localparam logic [1:0] KIND_ADD        = 2'd0;
    localparam logic [1:0] KIND_CANCEL     = 2'd1;
    localparam logic [1:0] KIND_CANCEL_ALL = 2'd2;
    localparam logic [1:0] KIND_TICK       = 2'd3;

    localparam logic [2:0] REPLY_ADDED     = 3'd0;
    localparam logic [2:0] REPLY_CANCEL    = 3'd1;
    localparam logic [2:0] REPLY_ALL       = 3'd2;
    localparam logic [2:0] REPLY_EXPIRED   = 3'd3;
    localparam logic [2:0] REPLY_IDLE      = 3'd4;

    localparam int MAX_REPLIES = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] duration;
        logic [15:0] cancel_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [15:0] reply_id;
        logic        ok;
        logic [4:0]  active_count;
        logic        last;
    } reply_t;

endpackage
`default_nettype wire

@@ src/multi_timer_deadline_scheduler.sv @@
// Bank of one-shot timers with earliest-deadline expiry. Commands enter a
// two-beat queue; an engine walks the timer slots one per cycle, except
// where it waits on the reply queue, and takes a new command only once its
// previous reply beat has moved on. An add scans for a free slot and then
// rescans the slots for each fresh id that collides; a cancel scans until
// the id is found, and a tick rescans once per expired timer. A full reply
// queue stalls the engine. Replies leave through a two-beat queue.
`default_nettype none
module multi_timer_deadline_scheduler
    import mtds_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire cmd_t   cmd,
    output logic        full,
    input  wire logic   pop,
    output reply_t      reply,
    output logic        empty
);

    logic   cq_empty;
    logic   cq_pop;
    cmd_t   cq_data;
    logic   rsp_valid;
    reply_t rsp;
    logic   rq_full;

    mtds_cmd_fifo u_cmd_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(cmd), .full(full),
        .pop(cq_pop), .pop_data(cq_data), .empty(cq_empty)
    );

    mtds_engine #(.TIMER_SLOTS(TIMER_SLOTS)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_empty(cq_empty), .cmd(cq_data),
        .cmd_pop(cq_pop), .rsp_valid(rsp_valid), .rsp(rsp), .rsp_full(rq_full)
    );

    mtds_reply_fifo u_reply_fifo (
        .clk(clk), .rst_n(rst_n), .push(rsp_valid), .push_data(rsp),
        .full(rq_full), .pop(pop), .pop_data(reply), .empty(empty)
    );

endmodule
`default_nettype wire

@@ src/mtds_cmd_fifo.sv @@
`default_nettype none
module mtds_cmd_fifo
    import mtds_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

@@ src/mtds_engine.sv @@
`default_nettype none
module mtds_engine
    import mtds_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cmd_empty,
    input  wire cmd_t   cmd,
    output logic        cmd_pop,
    output logic        rsp_valid,
    output reply_t      rsp,
    input  wire logic   rsp_full
);

`include "multi_timer_deadline_scheduler_assert.svh"

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TIMER_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD_SCAN, S_ADD_IDCHK, S_CAN_SCAN, S_TICK_SCAN, S_REPLY
    } state_t;

    state_t            state_reg;
    logic [47:0]       now_reg;
    logic [15:0]       id_counter_reg;
    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [15:0]       ident_reg [TIMER_SLOTS];
    logic [47:0]       dl_reg [TIMER_SLOTS];
    logic [CW-1:0]     active_reg;
    cmd_t              cmd_reg;
    logic [SW-1:0]     idx_reg;
    logic              found_reg;
    logic              more_reg;
    logic [SW-1:0]     free_reg;
    logic [15:0]       cand_reg;
    logic              clash_reg;
    logic [47:0]       best_age_reg;
    logic [15:0]       best_id_reg;
    logic [SW-1:0]     best_reg;
    logic [4:0]        emitted_reg;
    logic              rsp_valid_reg;
    reply_t            rsp_reg;

    logic [47:0] age;
    logic        reached;
    logic        better;
    logic        tick_last;
    logic        rsp_load;
    logic [15:0] cand_next;

    assign age = now_reg - dl_reg[idx_reg];
    assign reached = valid_reg[idx_reg] && !age[47];
    assign better = reached &&
        (!found_reg || age > best_age_reg ||
         (age == best_age_reg && ident_reg[idx_reg] < best_id_reg));
    assign tick_last = (emitted_reg == 5'(MAX_REPLIES - 1)) ||
                       !(more_reg || (reached && found_reg));
    assign rsp_load = (!rsp_valid_reg || !rsp_full) &&
        ((state_reg == S_REPLY) ||
         (state_reg == S_TICK_SCAN && idx_reg == LAST_SLOT && (better || found_reg)));
    assign cand_next = (cand_reg == 16'hFFFF) ? 16'd1 : cand_reg + 16'd1;
    assign cmd_pop   = (state_reg == S_IDLE) && !cmd_empty && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD_IDCHK && idx_reg == LAST_SLOT && !clash_reg &&
            !(valid_reg[idx_reg] && ident_reg[idx_reg] == cand_reg))
        begin
            ident_reg[free_reg] <= cand_reg;
            dl_reg[free_reg]    <= now_reg + {16'd0, cmd_reg.duration};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_full)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            id_counter_reg <= '0;
            valid_reg      <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            more_reg       <= 1'b0;
            emitted_reg    <= '0;
            clash_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty && !rsp_valid_reg)
                    begin
                        cmd_reg   <= cmd;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        more_reg  <= 1'b0;
                        unique case (cmd.kind)
                            KIND_ADD:    state_reg <= S_ADD_SCAN;
                            KIND_CANCEL: state_reg <= S_CAN_SCAN;
                            KIND_CANCEL_ALL:
                            begin
                                valid_reg  <= '0;
                                active_reg <= '0;
                                rsp_reg    <= '{REPLY_ALL, 16'd0, 1'b1, 5'd0, 1'b1};
                                state_reg  <= S_REPLY;
                            end
                            default:
                            begin
                                now_reg     <= now_reg + 48'd1;
                                emitted_reg <= '0;
                                state_reg   <= S_TICK_SCAN;
                            end
                        endcase
                    end
                end
                S_ADD_SCAN:
                begin
                    if (!valid_reg[idx_reg] && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        free_reg  <= idx_reg;
                    end
                    if (idx_reg == LAST_SLOT)
                    begin
                        idx_reg <= '0;
                        if (found_reg || !valid_reg[idx_reg])
                        begin
                            cand_reg  <= (id_counter_reg == 16'hFFFF) ? 16'd1
                                         : id_counter_reg + 16'd1;
                            clash_reg <= 1'b0;
                            state_reg <= S_ADD_IDCHK;
                        end
                        else
                        begin
                            rsp_reg   <= '{REPLY_ADDED, 16'd0, 1'b0, 5'(active_reg), 1'b1};
                            state_reg <= S_REPLY;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_ADD_IDCHK:
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        idx_reg <= '0;
                        if (clash_reg || (valid_reg[idx_reg] &&
                            ident_reg[idx_reg] == cand_reg))
                        begin
                            cand_reg  <= cand_next;
                            clash_reg <= 1'b0;
                        end
                        else
                        begin
                            id_counter_reg      <= cand_reg;
                            valid_reg[free_reg] <= 1'b1;
                            active_reg          <= active_reg + CW'(1);
                            rsp_reg <= '{REPLY_ADDED, cand_reg, 1'b1,
                                         5'(active_reg + CW'(1)), 1'b1};
                            state_reg <= S_REPLY;
                        end
                    end
                    else
                    begin
                        if (valid_reg[idx_reg] && ident_reg[idx_reg] == cand_reg)
                        begin
                            clash_reg <= 1'b1;
                        end
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_CAN_SCAN:
                begin
                    if (valid_reg[idx_reg] && ident_reg[idx_reg] == cmd_reg.cancel_id &&
                        cmd_reg.cancel_id != 16'd0)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        active_reg <= active_reg - CW'(1);
                        rsp_reg <= '{REPLY_CANCEL, cmd_reg.cancel_id, 1'b1,
                                     5'(active_reg - CW'(1)), 1'b1};
                        state_reg <= S_REPLY;
                    end
                    else if (idx_reg == LAST_SLOT)
                    begin
                        rsp_reg <= '{REPLY_CANCEL, cmd_reg.cancel_id, 1'b0,
                                     5'(active_reg), 1'b1};
                        state_reg <= S_REPLY;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_TICK_SCAN:
                begin
                    if (!rsp_valid_reg || !rsp_full)
                    begin
                        if (idx_reg == LAST_SLOT)
                        begin
                            idx_reg   <= '0;
                            found_reg <= 1'b0;
                            more_reg  <= 1'b0;
                            if (better || found_reg)
                            begin
                                valid_reg[better ? idx_reg : best_reg] <= 1'b0;
                                active_reg    <= active_reg - CW'(1);
                                emitted_reg   <= emitted_reg + 5'd1;
                                rsp_reg <= '{REPLY_EXPIRED,
                                    better ? ident_reg[idx_reg] : best_id_reg, 1'b1,
                                    5'(active_reg - CW'(1)), tick_last};
                                if (tick_last)
                                begin
                                    state_reg <= S_IDLE;
                                end
                            end
                            else
                            begin
                                rsp_reg   <= '{REPLY_IDLE, 16'd0, 1'b0,
                                               5'(active_reg), 1'b1};
                                state_reg <= S_REPLY;
                            end
                        end
                        else
                        begin
                            if (better)
                            begin
                                found_reg    <= 1'b1;
                                best_age_reg <= age;
                                best_id_reg  <= ident_reg[idx_reg];
                                best_reg     <= idx_reg;
                            end
                            if (reached && found_reg)
                            begin
                                more_reg <= 1'b1;
                            end
                            idx_reg <= idx_reg + SW'(1);
                        end
                    end
                end
                S_REPLY:
                begin
                    if (!rsp_valid_reg || !rsp_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `MTDS_ASSERT_IMPL(a_active_range, clk, rst_n, 1'b1, active_reg <= CW'(TIMER_SLOTS))
    `MTDS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid_reg && rsp_full,
                      rsp_valid_reg && $stable(rsp_reg))
    `MTDS_ASSERT_IMPL(a_pop_idle, clk, rst_n, cmd_pop, state_reg == S_IDLE)

endmodule
`default_nettype wire

@@ src/mtds_reply_fifo.sv @@
`default_nettype none
module mtds_reply_fifo
    import mtds_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire reply_t push_data,
    output logic        full,
    input  wire logic   pop,
    output reply_t      pop_data,
    output logic        empty
);

    reply_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire
